// File: rtl/assert_macros.svh
// Assertion macros shared by the paged translation RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define PAT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Condition that must never hold outside reset.
`define PAT_NEVER(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(expr)) else $error(msg);

`endif

// File: rtl/pat_pkg.sv
// Types and constants for the paged address translation block.
package pat_pkg;

    localparam int PAGE_SIZE_W  = 16;
    localparam int PAGE_COUNT_W = 5;
    localparam int FRAME_CNT_W  = 6;
    localparam int ADDR_W       = 32;
    localparam int PHYS_W       = 33;
    localparam int PNUM_W       = 4;
    localparam int FNUM_W       = 5;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PAGE_SIZE   = 2'd0,
        REG_PAGE_COUNT  = 2'd1,
        REG_FRAME_COUNT = 2'd2,
        REG_BASE_ADDR   = 2'd3
    } t_reg_idx;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_ABSENT      = 2'd1,
        ST_PAGE_RANGE  = 2'd2,
        ST_FRAME_RANGE = 2'd3
    } t_status;

    localparam logic OP_MAP       = 1'b0;
    localparam logic OP_TRANSLATE = 1'b1;

    typedef struct packed {
        logic              opcode;
        logic [PNUM_W-1:0] page_number;
        logic [FNUM_W-1:0] frame_number;
        logic [ADDR_W-1:0] logical_address;
    } t_in_item;

    typedef struct packed {
        logic [PHYS_W-1:0] physical_address;
        logic [1:0]        status;
    } t_out_item;

    typedef struct packed {
        logic start;
        logic done;
    } t_div_ctrl;

endpackage

// File: rtl/paged_address_translation_top.sv
// Paged address translation top level: config registers, sequencer, divider, page table, output register.
//
//   channel  | handshake                  | payload
//   ---------+----------------------------+------------------------------
//   input    | i_in_valid / o_in_stall    | i_in_item  (pat_pkg::t_in_item)
//   output   | o_out_valid / i_out_stall  | o_out_item (pat_pkg::t_out_item)
//   config   | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// Map: range check, table write if in range, then done. Translate: the 32-step divider,
// then table read, check, multiply and add; a page out of range ends after the divide,
// an absent page or stale frame after the check, and a zero page_size skips the divider.
// After reset a clearing pass over all MAX_PAGES entries zeroes the present bits; input stalls.
// One transaction at a time; the result register lets the next transaction start
// while a result waits, and the sequencer holds its result until the register frees.
`include "assert_macros.svh"

module paged_address_translation_top #(
    parameter int MAX_PAGES  = 16,
    parameter int MAX_FRAMES = 32
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_in_valid,
    output logic                                   o_in_stall,
    input  pat_pkg::t_in_item                      i_in_item,
    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output pat_pkg::t_out_item                     o_out_item,
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [pat_pkg::CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [pat_pkg::CFG_DATA_W-1:0]         i_cfg_data
);

    localparam int PW  = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
    localparam int FW  = pat_pkg::FNUM_W;
    localparam int EW  = FW + 1;
    localparam int SW  = pat_pkg::PAGE_SIZE_W;
    localparam int AW  = pat_pkg::ADDR_W;
    localparam int XW  = pat_pkg::PHYS_W;
    localparam int MW  = FW + SW;
    localparam int PCW = pat_pkg::PAGE_COUNT_W;
    localparam int FCW = pat_pkg::FRAME_CNT_W;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_MAP, S_DIV, S_LOOK, S_CHECK, S_MUL, S_ADD, S_DONE
    } t_state;

    t_state                  r_state, n_state;
    pat_pkg::t_in_item       r_item, n_item;
    logic [PW-1:0]           r_clr_idx, n_clr_idx;
    logic [FW-1:0]           r_frame, n_frame;
    logic [MW-1:0]           r_prod, n_prod;
    logic [XW-1:0]           r_addr, n_addr;
    pat_pkg::t_status        r_status, n_status;
    pat_pkg::t_out_item      r_out, n_out;
    logic                    r_out_valid, n_out_valid;

    logic [SW-1:0]           r_page_size;
    logic [PCW-1:0]          r_page_count;
    logic [FCW-1:0]          r_frame_count;
    logic [AW-1:0]           r_base;

    logic [PCW-1:0]          pages_limit;
    logic [FCW-1:0]          frames_limit;
    logic                    in_accept;
    logic                    out_take;
    logic                    div_start;
    pat_pkg::t_div_ctrl      div_ctrl;
    logic [AW-1:0]           div_quot;
    logic [SW-1:0]           div_rem;
    logic [31:0]             pnum_ext;
    logic                    ram_we;
    logic [PW-1:0]           ram_waddr;
    logic [EW-1:0]           ram_wdata;
    logic [EW-1:0]           ram_rdata;

    assign pages_limit  = (32'(r_page_count) > 32'(MAX_PAGES)) ? PCW'(MAX_PAGES)
                                                               : r_page_count;
    assign frames_limit = (32'(r_frame_count) > 32'(MAX_FRAMES)) ? FCW'(MAX_FRAMES)
                                                                 : r_frame_count;

    assign o_in_stall  = (r_state != S_IDLE);
    assign in_accept   = i_in_valid && !o_in_stall;
    assign out_take    = r_out_valid && !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;
    assign o_cfg_ready = 1'b1;

    assign div_start = in_accept && (i_in_item.opcode == pat_pkg::OP_TRANSLATE)
                       && (r_page_size != '0);
    assign pnum_ext  = 32'(r_item.page_number);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_page_size   <= SW'(1024);
            r_page_count  <= PCW'(16);
            r_frame_count <= FCW'(32);
            r_base        <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (pat_pkg::t_reg_idx'(i_cfg_index))
                pat_pkg::REG_PAGE_SIZE:   r_page_size   <= i_cfg_data[SW-1:0];
                pat_pkg::REG_PAGE_COUNT:  r_page_count  <= i_cfg_data[PCW-1:0];
                pat_pkg::REG_FRAME_COUNT: r_frame_count <= i_cfg_data[FCW-1:0];
                pat_pkg::REG_BASE_ADDR:   r_base        <= i_cfg_data[AW-1:0];
                default: ;
            endcase
        end
    end

    pat_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (i_in_item.logical_address),
        .i_divisor  (r_page_size),
        .o_ctrl     (div_ctrl),
        .o_quot     (div_quot),
        .o_rem      (div_rem)
    );

    // entry = {present, frame}
    pat_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_PAGES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (div_quot[PW-1:0]),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state     = r_state;
        n_item      = r_item;
        n_clr_idx   = r_clr_idx;
        n_frame     = r_frame;
        n_prod      = r_prod;
        n_addr      = r_addr;
        n_status    = r_status;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        ram_we      = 1'b0;
        ram_waddr   = pnum_ext[PW-1:0];
        ram_wdata   = {1'b1, r_item.frame_number};

        if (out_take) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr_idx;
                ram_wdata = '0;
                n_clr_idx = r_clr_idx + PW'(1);
                if (r_clr_idx == PW'(MAX_PAGES - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_accept) begin
                    n_item   = i_in_item;
                    n_addr   = '0;
                    n_status = pat_pkg::ST_OK;
                    if (i_in_item.opcode == pat_pkg::OP_MAP) begin
                        n_state = S_MAP;
                    end else if (r_page_size == '0) begin
                        n_status = pat_pkg::ST_PAGE_RANGE;
                        n_state  = S_DONE;
                    end else begin
                        n_state = S_DIV;
                    end
                end
            end
            S_MAP: begin
                if ({1'b0, r_item.page_number} >= pages_limit) begin
                    n_status = pat_pkg::ST_PAGE_RANGE;
                end else if ({1'b0, r_item.frame_number} >= frames_limit) begin
                    n_status = pat_pkg::ST_FRAME_RANGE;
                end else begin
                    ram_we = 1'b1;
                end
                n_state = S_DONE;
            end
            S_DIV: begin
                if (div_ctrl.done) begin
                    n_state = S_LOOK;
                end
            end
            S_LOOK: begin
                if (div_quot >= AW'(pages_limit)) begin
                    n_status = pat_pkg::ST_PAGE_RANGE;
                    n_state  = S_DONE;
                end else begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                n_frame = ram_rdata[FW-1:0];
                if (!ram_rdata[FW]) begin
                    n_status = pat_pkg::ST_ABSENT;
                    n_state  = S_DONE;
                end else if ({1'b0, ram_rdata[FW-1:0]} >= frames_limit) begin
                    n_status = pat_pkg::ST_FRAME_RANGE;
                    n_state  = S_DONE;
                end else begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_prod  = MW'(r_frame) * MW'(r_page_size);
                n_state = S_ADD;
            end
            S_ADD: begin
                n_addr  = XW'(r_base) + XW'(r_prod) + XW'(div_rem);
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || out_take) begin
                    n_out.physical_address = r_addr;
                    n_out.status           = r_status;
                    n_out_valid            = 1'b1;
                    n_state                = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_idx   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_idx   <= n_clr_idx;
            r_out_valid <= n_out_valid;
        end
        r_item   <= n_item;
        r_frame  <= n_frame;
        r_prod   <= n_prod;
        r_addr   <= n_addr;
        r_status <= n_status;
        r_out    <= n_out;
    end

    `PAT_ASSERT(a_err_zero_addr, (o_out_valid && (o_out_item.status != pat_pkg::ST_OK)) |-> (o_out_item.physical_address == '0), "error result with nonzero address")
    `PAT_ASSERT(a_done_in_div, div_ctrl.done |-> (r_state == S_DIV), "divider done outside divide state")
    `PAT_ASSERT(a_out_from_done, $rose(o_out_valid) |-> ($past(r_state) == S_DONE), "result loaded outside done state")
    `PAT_NEVER(a_no_write_translate, ram_we && (r_state != S_CLEAR) && (r_item.opcode == pat_pkg::OP_TRANSLATE), "table written by translate")

endmodule

// File: rtl/pat_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pat_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/pat_div.sv
// Restoring divider: 32-bit dividend by 16-bit divisor, one quotient bit per cycle.
`include "assert_macros.svh"

module pat_div (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic [pat_pkg::ADDR_W-1:0]         i_dividend,
    input  logic [pat_pkg::PAGE_SIZE_W-1:0]    i_divisor,
    output pat_pkg::t_div_ctrl                 o_ctrl,
    output logic [pat_pkg::ADDR_W-1:0]         o_quot,
    output logic [pat_pkg::PAGE_SIZE_W-1:0]    o_rem
);

    localparam int DW = pat_pkg::PAGE_SIZE_W;
    localparam int QW = pat_pkg::ADDR_W;
    localparam int CW = $clog2(QW);

    logic          r_busy, n_busy;
    logic          r_done, n_done;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [QW-1:0] r_q, n_q;
    logic [DW-1:0] r_rem, n_rem;
    logic [DW-1:0] r_div, n_div;

    logic [DW:0]   shifted;
    logic [DW+1:0] diff;
    logic          ge;

    always_comb begin
        shifted = {r_rem, r_q[QW-1]};
        diff    = {1'b0, shifted} - {2'b00, r_div};
        ge      = ~diff[DW+1];

        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_q    = r_q;
        n_rem  = r_rem;
        n_div  = r_div;

        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CW'(QW - 1);
            n_q    = i_dividend;
            n_rem  = '0;
            n_div  = i_divisor;
        end else if (r_busy) begin
            n_q   = {r_q[QW-2:0], ge};
            n_rem = ge ? diff[DW-1:0] : shifted[DW-1:0];
            n_cnt = r_cnt - CW'(1);
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_q   <= n_q;
        r_rem <= n_rem;
        r_div <= n_div;
    end

    assign o_ctrl.start = i_start;
    assign o_ctrl.done  = r_done;
    assign o_quot       = r_q;
    assign o_rem        = r_rem;

    `PAT_ASSERT(a_done_after_busy, r_done |-> $past(r_busy), "divider done without busy")
    `PAT_NEVER(a_no_restart, i_start && r_busy, "divider restarted while busy")
    `PAT_NEVER(a_busy_and_done, r_busy && r_done, "divider done while still busy")

endmodule

// File: sim/tb_top.sv
// Testbench for paged_address_translation_top: directed and random map/translate traffic.
module tb_top;
    import pat_pkg::*;

    class xlate_scoreboard;
        logic [PAGE_SIZE_W-1:0]  page_size;
        logic [PAGE_COUNT_W-1:0] page_count;
        logic [FRAME_CNT_W-1:0]  frame_count;
        logic [ADDR_W-1:0]       base_addr;
        logic [FNUM_W-1:0]       frame_tbl [16];
        bit                      present [16];
        t_out_item               expected_xlate_q [$];
        int                      errors;

        function new();
            page_size   = 16'd1024;
            page_count  = 5'd16;
            frame_count = 6'd32;
            base_addr   = '0;
            errors      = 0;
            foreach (present[i]) begin
                present[i]   = 1'b0;
                frame_tbl[i] = '0;
            end
        endfunction

        function void set_reg(t_reg_idx idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_PAGE_SIZE:   page_size   = data[PAGE_SIZE_W-1:0];
                REG_PAGE_COUNT:  page_count  = data[PAGE_COUNT_W-1:0];
                REG_FRAME_COUNT: frame_count = data[FRAME_CNT_W-1:0];
                REG_BASE_ADDR:   base_addr   = data[ADDR_W-1:0];
                default: ;
            endcase
        endfunction

        function int unsigned pages_lim();
            return (page_count > 16) ? 16 : page_count;
        endfunction

        function int unsigned frames_lim();
            return (frame_count > 32) ? 32 : frame_count;
        endfunction

        // Predict the result of one accepted transaction and update the page table.
        function void note_input(t_in_item it);
            t_out_item         r;
            logic [ADDR_W-1:0] page;
            logic [ADDR_W-1:0] offset;
            logic [63:0]       sum;
            r.physical_address = '0;
            if (it.opcode == OP_MAP) begin
                if (it.page_number >= pages_lim()) begin
                    r.status = ST_PAGE_RANGE;
                end else if (it.frame_number >= frames_lim()) begin
                    r.status = ST_FRAME_RANGE;
                end else begin
                    frame_tbl[it.page_number] = it.frame_number;
                    present[it.page_number]   = 1'b1;
                    r.status = ST_OK;
                end
            end else if (page_size == 0) begin
                r.status = ST_PAGE_RANGE;
            end else begin
                page   = it.logical_address / {16'd0, page_size};
                offset = it.logical_address % {16'd0, page_size};
                if (page >= pages_lim()) begin
                    r.status = ST_PAGE_RANGE;
                end else if (!present[page[3:0]]) begin
                    r.status = ST_ABSENT;
                end else if (frame_tbl[page[3:0]] >= frames_lim()) begin
                    r.status = ST_FRAME_RANGE;
                end else begin
                    sum = 64'(base_addr) + 64'(frame_tbl[page[3:0]]) * 64'(page_size)
                        + 64'(offset);
                    r.physical_address = sum[PHYS_W-1:0];
                    r.status = ST_OK;
                end
            end
            expected_xlate_q.push_back(r);
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            if (expected_xlate_q.size() == 0) begin
                $error("result with no transaction pending: %h", got);
                errors++;
                return;
            end
            want = expected_xlate_q.pop_front();
            if (got.physical_address !== want.physical_address) begin
                $error("physical_address: expected %h, got %h",
                       want.physical_address, got.physical_address);
                errors++;
            end
            if (got.status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                errors++;
            end
        endfunction
    endclass

    logic                  clk         = 1'b0;
    logic                  rst_n       = 1'b0;
    logic                  in_valid    = 1'b0;
    t_in_item              in_item     = '0;
    logic                  out_stall   = 1'b0;
    logic                  cfg_valid   = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index   = '0;
    logic [CFG_DATA_W-1:0] cfg_data    = '0;
    logic                  o_in_stall;
    logic                  o_out_valid;
    t_out_item             o_out_item;
    logic                  o_cfg_ready;
    int                    stall_mode  = 0;
    int                    stall_left  = 0;
    xlate_scoreboard       sb;

    paged_address_translation_top i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (o_out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #1 clk = ~clk;

    // Receiver stall pattern: modes from never stalling to mostly stalled.
    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall  <= 1'b0;
            stall_mode <= 0;
            stall_left <= 0;
        end else begin
            if (stall_left == 0) begin
                stall_mode <= $urandom_range(0, 3);
                stall_left <= $urandom_range(20, 400);
            end else begin
                stall_left <= stall_left - 1;
            end
            case (stall_mode)
                0:       out_stall <= 1'b0;
                1:       out_stall <= ($urandom_range(0, 3) == 0);
                2:       out_stall <= 1'($urandom_range(0, 1));
                default: out_stall <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    always @(posedge clk) begin
        if (rst_n && o_out_valid && !out_stall) begin
            sb.check_result(o_out_item);
        end
    end

    task automatic send_item(t_in_item it);
        in_valid <= 1'b1;
        in_item  <= it;
        do @(posedge clk); while (o_in_stall);
        sb.note_input(it);
    endtask

    task automatic write_reg(t_reg_idx idx, logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!o_cfg_ready);
        sb.set_reg(idx, data);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (sb.expected_xlate_q.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    function automatic t_in_item mk_map(logic [PNUM_W-1:0] p, logic [FNUM_W-1:0] f);
        t_in_item it;
        it.opcode          = OP_MAP;
        it.page_number     = p;
        it.frame_number    = f;
        it.logical_address = $urandom;
        return it;
    endfunction

    function automatic t_in_item mk_xlate(logic [ADDR_W-1:0] a);
        t_in_item it;
        it.opcode          = OP_TRANSLATE;
        it.page_number     = PNUM_W'($urandom);
        it.frame_number    = FNUM_W'($urandom);
        it.logical_address = a;
        return it;
    endfunction

    // Mostly in-range maps and addresses built from valid pages; some noise.
    function automatic t_in_item random_item();
        t_in_item    it;
        int unsigned pl;
        int unsigned fl;
        int unsigned ps;
        int unsigned page;
        int unsigned sel;
        pl  = sb.pages_lim();
        fl  = sb.frames_lim();
        ps  = 32'(sb.page_size);
        sel = $urandom_range(0, 99);
        it.opcode          = 1'($urandom);
        it.page_number     = PNUM_W'($urandom);
        it.frame_number    = FNUM_W'($urandom);
        it.logical_address = $urandom;
        if (sel < 10) begin
            return it;
        end else if (sel < 45) begin
            it.opcode = OP_MAP;
            if (pl > 0 && $urandom_range(0, 4) != 0)
                it.page_number = PNUM_W'($urandom_range(0, pl - 1));
            if (fl > 0 && $urandom_range(0, 4) != 0)
                it.frame_number = FNUM_W'($urandom_range(0, fl - 1));
        end else begin
            it.opcode = OP_TRANSLATE;
            if (ps != 0 && sel < 92) begin
                if (pl > 0 && $urandom_range(0, 5) != 0) page = $urandom_range(0, pl - 1);
                else page = $urandom_range(0, 17);
                it.logical_address = page * ps + $urandom_range(0, ps - 1);
            end
        end
        return it;
    endfunction

    task automatic random_config();
        logic [PAGE_SIZE_W-1:0]  ps;
        logic [PAGE_COUNT_W-1:0] pc;
        logic [FRAME_CNT_W-1:0]  fc;
        logic [ADDR_W-1:0]       base;
        case ($urandom_range(0, 9))
            0:       ps = 16'd0;
            1:       ps = 16'd1;
            2:       ps = 16'hFFFF;
            3, 4, 5: ps = PAGE_SIZE_W'($urandom_range(2, 16));
            default: ps = PAGE_SIZE_W'($urandom_range(1, 65535));
        endcase
        case ($urandom_range(0, 7))
            0:       pc = 5'd0;
            1:       pc = PAGE_COUNT_W'($urandom_range(17, 31));
            2:       pc = 5'd16;
            default: pc = PAGE_COUNT_W'($urandom_range(1, 16));
        endcase
        case ($urandom_range(0, 7))
            0:       fc = 6'd0;
            1:       fc = FRAME_CNT_W'($urandom_range(33, 63));
            2:       fc = 6'd32;
            default: fc = FRAME_CNT_W'($urandom_range(1, 32));
        endcase
        case ($urandom_range(0, 3))
            0:       base = '0;
            1:       base = '1;
            default: base = $urandom;
        endcase
        if ($urandom_range(0, 3) != 0) write_reg(REG_PAGE_SIZE, 32'(ps));
        if ($urandom_range(0, 3) != 0) write_reg(REG_PAGE_COUNT, 32'(pc));
        if ($urandom_range(0, 3) != 0) write_reg(REG_FRAME_COUNT, 32'(fc));
        if ($urandom_range(0, 3) != 0) write_reg(REG_BASE_ADDR, base);
    endtask

    initial begin
        #4000000;
        $display("tb_top: errors");
        $finish;
    end

    initial begin
        int phase;
        int n;
        int k;
        int burst;
        int gap;
        sb = new();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // default setup: absent page, maps, edges of the page range, remap
        send_item(mk_xlate(32'd0));
        send_item(mk_map(4'd0, 5'd31));
        send_item(mk_map(4'd15, 5'd0));
        send_item(mk_map(4'd3, 5'd5));
        send_item(mk_xlate(32'd1023));
        send_item(mk_xlate(32'd16383));
        send_item(mk_xlate(32'd16384));
        send_item(mk_xlate(32'hFFFF_FFFF));
        send_item(mk_xlate(32'd3079));
        send_item(mk_map(4'd3, 5'd7));
        send_item(mk_xlate(32'd3072));

        // lowered counts: range checks on map, stale frame on translate
        wait_idle();
        write_reg(REG_PAGE_COUNT, 32'd4);
        write_reg(REG_FRAME_COUNT, 32'd8);
        send_item(mk_map(4'd4, 5'd0));
        send_item(mk_map(4'd2, 5'd8));
        send_item(mk_map(4'd5, 5'd31));
        send_item(mk_xlate(32'd0));
        send_item(mk_xlate(32'd15360));
        send_item(mk_map(4'd1, 5'd1));

        wait_idle();
        write_reg(REG_PAGE_SIZE, 32'd0);
        send_item(mk_xlate(32'd1024));
        send_item(mk_map(4'd2, 5'd2));

        wait_idle();
        write_reg(REG_PAGE_SIZE, 32'd3);
        write_reg(REG_PAGE_COUNT, 32'd16);
        send_item(mk_xlate(32'd5));

        // largest page, oversized counts, top base
        wait_idle();
        write_reg(REG_PAGE_SIZE, 32'hFFFF);
        write_reg(REG_PAGE_COUNT, 32'd31);
        write_reg(REG_FRAME_COUNT, 32'd63);
        write_reg(REG_BASE_ADDR, 32'hFFFF_FFFF);
        send_item(mk_map(4'd15, 5'd31));
        send_item(mk_xlate(32'd1048559));
        send_item(mk_xlate(32'hFFFF_FFFF));

        wait_idle();
        write_reg(REG_PAGE_COUNT, 32'd0);
        write_reg(REG_FRAME_COUNT, 32'd0);
        send_item(mk_map(4'd0, 5'd0));
        send_item(mk_xlate(32'd0));

        for (phase = 0; phase < 8; phase++) begin
            wait_idle();
            random_config();
            n = 0;
            while (n < 160) begin
                burst = $urandom_range(1, 24);
                for (k = 0; k < burst && n < 160; k++) begin
                    send_item(random_item());
                    n++;
                end
                case ($urandom_range(0, 7))
                    0, 1:    gap = 0;
                    2:       gap = $urandom_range(20, 60);
                    default: gap = $urandom_range(1, 8);
                endcase
                if (gap != 0) begin
                    in_valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
        end

        wait_idle();
        repeat (50) @(posedge clk);
        if (sb.errors == 0 && sb.expected_xlate_q.size() == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end
endmodule
